// ===== rtl/ofrp_pkg.sv =====
// Package for the object-file record parser.
// Holds the phase, record-type and result-kind encodings and the header constants.
// No dependencies.
`default_nettype none

package ofrp_pkg;

    typedef enum logic [3:0] {
        PH_HDR0,
        PH_HDR1,
        PH_ADR0,
        PH_ADR1,
        PH_CNT0,
        PH_CNT1,
        PH_WRD0,
        PH_WRD1,
        PH_LABEL,
        PH_SKIP,
        PH_ERROR
    } phase_t;

    typedef enum logic [1:0] {
        RT_CODE,
        RT_SYMBOL,
        RT_FILE,
        RT_LINE
    } rec_t;

    typedef enum logic [1:0] {
        K_WORD,
        K_LABEL,
        K_EMPTY,
        K_BAD_HDR
    } kind_t;

    localparam int ADDR_W  = 16;
    localparam int CNT_W   = 16;
    localparam int VALUE_W = 16;

    // record headers, first byte then second byte
    localparam logic [7:0] HDR_CODE0 = 8'hCA;
    localparam logic [7:0] HDR_CODE1 = 8'hDE;
    localparam logic [7:0] HDR_DATA  = 8'hDA;
    localparam logic [7:0] HDR_SYM0  = 8'hC3;
    localparam logic [7:0] HDR_SYM1  = 8'hB7;
    localparam logic [7:0] HDR_FILE0 = 8'hF1;
    localparam logic [7:0] HDR_FILE1 = 8'h7E;
    localparam logic [7:0] HDR_LINE0 = 8'h71;
    localparam logic [7:0] HDR_LINE1 = 8'h5E;

    localparam logic [CNT_W-1:0] LINE_SKIP = CNT_W'(6);

endpackage

`default_nettype wire

// ===== rtl/object_file_record_parser_top.sv =====
// Object-file record parser: decodes a byte stream of object-file records into
// word-write, label-character, empty-label and bad-header requests.
// Depends on ofrp_pkg.
//
// Results are registered: a result appears on the master side in the cycle after the byte that causes it.
// Throughput: one byte per cycle unless the output stalls; the phase machine updates on every accepted byte.
// The single output register stalls input only while it holds an untaken request.
// Reset (rst_n low, asynchronous) returns to waiting for a header and clears the
// output valid; after a bad header the block ignores all bytes until reset.
`default_nettype none

module object_file_record_parser_top
    import ofrp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] stream_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [15:0] address, [31:16] value
    output logic [1:0]       m_tuser,   // [1:0] kind
    output logic             m_tlast    // label_last
);

    phase_t             phase_reg, phase_next;
    rec_t               rtype_reg, rtype_next;
    logic [7:0]         held_reg, held_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    logic               m_valid_reg, m_valid_next;
    kind_t              m_kind_reg;
    logic [ADDR_W-1:0]  m_addr_reg;
    logic [VALUE_W-1:0] m_value_reg;
    logic               m_last_reg;

    logic               in_acc;
    logic               res_valid;
    kind_t              res_kind;
    logic [ADDR_W-1:0]  res_addr;
    logic [VALUE_W-1:0] res_value;
    logic               res_last;
    logic [15:0]        pair;
    logic               cnt_one;

    assign s_tready = !m_valid_reg || m_tready;
    assign in_acc   = s_tvalid && s_tready;
    assign pair     = {held_reg, s_tdata};
    assign cnt_one  = (cnt_reg == CNT_W'(1));

    // next state of the record phase machine
    always_comb
    begin
        phase_next = phase_reg;
        rtype_next = rtype_reg;
        held_next  = held_reg;
        addr_next  = addr_reg;
        cnt_next   = cnt_reg;
        if (in_acc)
        begin
            unique case (phase_reg) inside
                PH_HDR0, PH_ADR0, PH_CNT0, PH_WRD0:
                begin
                    held_next  = s_tdata;
                    phase_next = phase_t'(phase_reg + 4'd1);
                end
                PH_HDR1:
                begin
                    if ((held_reg == HDR_CODE0 && s_tdata == HDR_CODE1) ||
                        (held_reg == HDR_DATA && s_tdata == HDR_DATA))
                    begin
                        rtype_next = RT_CODE;
                        phase_next = PH_ADR0;
                    end
                    else if (held_reg == HDR_SYM0 && s_tdata == HDR_SYM1)
                    begin
                        rtype_next = RT_SYMBOL;
                        phase_next = PH_ADR0;
                    end
                    else if (held_reg == HDR_FILE0 && s_tdata == HDR_FILE1)
                    begin
                        rtype_next = RT_FILE;
                        phase_next = PH_CNT0;
                    end
                    else if (held_reg == HDR_LINE0 && s_tdata == HDR_LINE1)
                    begin
                        rtype_next = RT_LINE;
                        cnt_next   = LINE_SKIP;
                        phase_next = PH_SKIP;
                    end
                    else
                    begin
                        phase_next = PH_ERROR;
                    end
                end
                PH_ADR1:
                begin
                    addr_next  = ADDR_W'(pair);
                    phase_next = PH_CNT0;
                end
                PH_CNT1:
                begin
                    cnt_next = CNT_W'(pair);
                    if (pair == 16'd0)
                        phase_next = PH_HDR0;
                    else if (rtype_reg == RT_CODE)
                        phase_next = PH_WRD0;
                    else if (rtype_reg == RT_SYMBOL)
                        phase_next = PH_LABEL;
                    else
                        phase_next = PH_SKIP;
                end
                PH_WRD1:
                begin
                    addr_next  = addr_reg + ADDR_W'(1);
                    cnt_next   = cnt_reg - CNT_W'(1);
                    phase_next = cnt_one ? PH_HDR0 : PH_WRD0;
                end
                PH_LABEL, PH_SKIP:
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                    if (cnt_one)
                        phase_next = PH_HDR0;
                end
                PH_ERROR:
                begin
                    phase_next = PH_ERROR;
                end
                default:
                begin
                    phase_next = PH_HDR0;
                end
            endcase
        end
    end

    // request produced by the accepted byte
    always_comb
    begin
        res_valid = 1'b0;
        res_kind  = K_WORD;
        res_addr  = addr_reg;
        res_value = VALUE_W'(pair);
        res_last  = 1'b0;
        if (in_acc)
        begin
            unique case (phase_reg)
                PH_HDR1:
                begin
                    if (!((held_reg == HDR_CODE0 && s_tdata == HDR_CODE1) ||
                          (held_reg == HDR_DATA && s_tdata == HDR_DATA) ||
                          (held_reg == HDR_SYM0 && s_tdata == HDR_SYM1) ||
                          (held_reg == HDR_FILE0 && s_tdata == HDR_FILE1) ||
                          (held_reg == HDR_LINE0 && s_tdata == HDR_LINE1)))
                    begin
                        res_valid = 1'b1;
                        res_kind  = K_BAD_HDR;
                        res_addr  = '0;
                    end
                end
                PH_CNT1:
                begin
                    if (rtype_reg == RT_SYMBOL && pair == 16'd0)
                    begin
                        res_valid = 1'b1;
                        res_kind  = K_EMPTY;
                        res_value = '0;
                        res_last  = 1'b1;
                    end
                end
                PH_WRD1:
                begin
                    res_valid = 1'b1;
                end
                PH_LABEL:
                begin
                    res_valid = 1'b1;
                    res_kind  = K_LABEL;
                    res_value = VALUE_W'(s_tdata);
                    res_last  = cnt_one;
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    assign m_valid_next = res_valid || (m_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HDR0;
            rtype_reg   <= RT_CODE;
            held_reg    <= '0;
            addr_reg    <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            rtype_reg   <= rtype_next;
            held_reg    <= held_next;
            addr_reg    <= addr_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            m_kind_reg  <= res_kind;
            m_addr_reg  <= res_addr;
            m_value_reg <= res_value;
            m_last_reg  <= res_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_value_reg, m_addr_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    // a bad header locks the parser until reset
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ERROR |=> phase_reg == PH_ERROR)
        else $error("parser left error phase");

    // every second word byte yields a write request
    a_word_emits: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && phase_reg == PH_WRD1 |=> m_tvalid && m_tuser == K_WORD)
        else $error("word byte produced no write request");

    // last label character is flagged and ends the record
    a_label_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && phase_reg == PH_LABEL && cnt_one |=>
            m_tvalid && m_tlast && phase_reg == PH_HDR0)
        else $error("final label character mishandled");

    // tlast only marks label requests
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser == K_LABEL || m_tuser == K_EMPTY)
        else $error("tlast on non-label request");

endmodule

`default_nettype wire
